@@ hdl/c3d_pkg.sv @@
package c3d_pkg;

  localparam int unsigned DefMaxWidth  = 64;
  localparam int unsigned DefMaxHeight = 64;
  localparam int unsigned DefMaxDepth  = 64;
  localparam int unsigned DefMaxKernel = 5;

  localparam int unsigned SampleW = 16;
  localparam int unsigned IdxW    = 7;
  localparam int unsigned CoordW  = 6;
  localparam int unsigned JobW    = 10;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned CfgW    = 7;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned AccW    = 48;

  typedef enum logic [CfgIdxW-1:0] {
    RegWidth  = 2'd0,
    RegHeight = 2'd1,
    RegDepth  = 2'd2,
    RegKernel = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    BkIdle,
    BkRun,
    BkDrain,
    BkOut
  } bk_state_e;

  typedef struct packed {
    logic [JobW-1:0] ox;
    logic [JobW-1:0] oy;
    logic [JobW-1:0] oz;
    logic            last;
  } job_t;

endpackage

@@ hdl/conv3d_valid_stream_top.sv @@
// A voxel that completes a window occupies the back end, which forms one
// weight-sample product per cycle through the single plane memory read
// port; voxels without a result and weight loads do not occupy it. One
// result is held for pop while the next voxel is accepted.
module conv3d_valid_stream_top import c3d_pkg::*; #(
  parameter int unsigned MaxWidth  = DefMaxWidth,
  parameter int unsigned MaxHeight = DefMaxHeight,
  parameter int unsigned MaxDepth  = DefMaxDepth,
  parameter int unsigned MaxKernel = DefMaxKernel
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  logic action_i,
  input  logic [IdxW-1:0] weight_index_i,
  input  logic signed [SampleW-1:0] sample_value_i,
  output logic empty,
  input  logic pop,
  output logic signed [ValueW-1:0] out_value_o,
  output logic [CoordW-1:0] out_x_o,
  output logic [CoordW-1:0] out_y_o,
  output logic [CoordW-1:0] out_z_o,
  output logic last_o,
  input  logic cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0] cfg_data_i
);

  localparam int unsigned XW = (MaxWidth  > 1) ? $clog2(MaxWidth)  : 1;
  localparam int unsigned YW = (MaxHeight > 1) ? $clog2(MaxHeight) : 1;
  localparam int unsigned SW = (MaxKernel > 1) ? $clog2(MaxKernel) : 1;
  localparam int unsigned WAW = $clog2(MaxKernel * MaxKernel * MaxKernel + 1);

  logic [CfgW-1:0] w_q, h_q, d_q;
  logic [2:0] k_q;
  logic acc, busy, wt_we, px_we, job;
  logic [WAW-1:0] wt_addr;
  logic [SW-1:0] px_slot;
  logic [YW-1:0] px_y;
  logic [XW-1:0] px_x;
  job_t job_data, out_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q <= 7'd8; h_q <= 7'd8; d_q <= 7'd8; k_q <= 3'd3;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        RegWidth:  w_q <= cfg_data_i;
        RegHeight: h_q <= cfg_data_i;
        RegDepth:  d_q <= cfg_data_i;
        RegKernel: k_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  assign full = busy;
  assign acc = push && !full;

  c3d_front #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight), .MaxDepth(MaxDepth),
              .MaxKernel(MaxKernel)) u_front (
    .clk_i, .rst_ni, .acc_i(acc), .action_i, .weight_index_i,
    .sample_value_i, .w_i(w_q), .h_i(h_q), .d_i(d_q), .k_i(k_q),
    .wt_we_o(wt_we), .wt_addr_o(wt_addr), .px_we_o(px_we), .px_slot_o(px_slot),
    .px_y_o(px_y), .px_x_o(px_x), .job_o(job), .job_data_o(job_data)
  );

  c3d_back #(.MaxWidth(MaxWidth), .MaxHeight(MaxHeight), .MaxKernel(MaxKernel)) u_back (
    .clk_i, .rst_ni, .wt_we_i(wt_we), .wt_addr_i(wt_addr), .px_we_i(px_we),
    .px_slot_i(px_slot), .px_y_i(px_y), .px_x_i(px_x), .sample_i(sample_value_i),
    .k_i(k_q), .job_i(job), .job_data_i(job_data), .busy_o(busy), .empty_o(empty),
    .pop_i(pop), .out_value_o, .out_job_o(out_job)
  );

  assign out_x_o = out_job.ox[CoordW-1:0];
  assign out_y_o = out_job.oy[CoordW-1:0];
  assign out_z_o = out_job.oz[CoordW-1:0];
  assign last_o = out_job.last;

`ifndef SYNTHESIS
  a_no_push_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !acc) else $error("word accepted while back end busy");
  a_pop_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !busy) |=> empty) else $error("result not cleared on pop");
`endif

endmodule

@@ hdl/c3d_front.sv @@
module c3d_front import c3d_pkg::*; #(
  parameter int unsigned MaxWidth  = DefMaxWidth,
  parameter int unsigned MaxHeight = DefMaxHeight,
  parameter int unsigned MaxDepth  = DefMaxDepth,
  parameter int unsigned MaxKernel = DefMaxKernel,
  parameter int unsigned XW = (MaxWidth  > 1) ? $clog2(MaxWidth)  : 1,
  parameter int unsigned YW = (MaxHeight > 1) ? $clog2(MaxHeight) : 1,
  parameter int unsigned SW = (MaxKernel > 1) ? $clog2(MaxKernel) : 1,
  parameter int unsigned WAW = $clog2(MaxKernel * MaxKernel * MaxKernel + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               acc_i,
  input  logic               action_i,
  input  logic [IdxW-1:0]    weight_index_i,
  input  logic signed [SampleW-1:0] sample_value_i,
  input  logic [CfgW-1:0]    w_i,
  input  logic [CfgW-1:0]    h_i,
  input  logic [CfgW-1:0]    d_i,
  input  logic [2:0]         k_i,
  output logic               wt_we_o,
  output logic [WAW-1:0]     wt_addr_o,
  output logic               px_we_o,
  output logic [SW-1:0]      px_slot_o,
  output logic [YW-1:0]      px_y_o,
  output logic [XW-1:0]      px_x_o,
  output logic               job_o,
  output job_t               job_data_o
);

  localparam int unsigned WWords = MaxKernel * MaxKernel * MaxKernel;

  logic [10:0] px_q, px_d, py_q, py_d, pz_q, pz_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [10:0] w, h, d, k, x, y, z;
  logic        oob, go;

  always_comb begin
    w = (w_i == '0) ? 11'd1 : ((11'(w_i) > 11'(MaxWidth))  ? 11'(MaxWidth)  : 11'(w_i));
    h = (h_i == '0) ? 11'd1 : ((11'(h_i) > 11'(MaxHeight)) ? 11'(MaxHeight) : 11'(h_i));
    d = (d_i == '0) ? 11'd1 : ((11'(d_i) > 11'(MaxDepth))  ? 11'(MaxDepth)  : 11'(d_i));
    k = (k_i == '0) ? 11'd1 : ((11'(k_i) > 11'(MaxKernel)) ? 11'(MaxKernel) : 11'(k_i));
    oob = (px_q >= w) || (py_q >= h) || (pz_q >= d);
    x = oob ? '0 : px_q;
    y = oob ? '0 : py_q;
    z = oob ? '0 : pz_q;
    go = acc_i && action_i;
    wt_we_o = acc_i && !action_i && (32'(weight_index_i) < WWords);
    wt_addr_o = WAW'(weight_index_i);
    px_we_o = go;
    px_slot_o = oob ? '0 : slot_q;
    px_x_o = XW'(x);
    px_y_o = YW'(y);
    job_o = go && (x + 11'd1 >= k) && (y + 11'd1 >= k) && (z + 11'd1 >= k);
    job_data_o.ox = JobW'(x + 11'd1 - k);
    job_data_o.oy = JobW'(y + 11'd1 - k);
    job_data_o.oz = JobW'(z + 11'd1 - k);
    job_data_o.last = (x == w - 11'd1) && (y == h - 11'd1) && (z == d - 11'd1);
    px_d = px_q; py_d = py_q; pz_d = pz_q; slot_d = slot_q;
    if (go) begin
      slot_d = px_slot_o;
      if (x + 11'd1 < w) begin
        px_d = x + 11'd1; py_d = y; pz_d = z;
      end else begin
        px_d = '0;
        if (y + 11'd1 < h) begin
          py_d = y + 11'd1; pz_d = z;
        end else begin
          py_d = '0;
          if (z + 11'd1 < d) begin
            pz_d = z + 11'd1;
            slot_d = (32'(px_slot_o) == MaxKernel - 1) ? '0 : px_slot_o + SW'(1);
          end else begin
            pz_d = '0;
            slot_d = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= '0; py_q <= '0; pz_q <= '0; slot_q <= '0;
    end else begin
      px_q <= px_d; py_q <= py_d; pz_q <= pz_d; slot_q <= slot_d;
    end
  end

endmodule

@@ hdl/c3d_back.sv @@
module c3d_back import c3d_pkg::*; #(
  parameter int unsigned MaxWidth  = DefMaxWidth,
  parameter int unsigned MaxHeight = DefMaxHeight,
  parameter int unsigned MaxKernel = DefMaxKernel,
  parameter int unsigned XW = (MaxWidth  > 1) ? $clog2(MaxWidth)  : 1,
  parameter int unsigned YW = (MaxHeight > 1) ? $clog2(MaxHeight) : 1,
  parameter int unsigned SW = (MaxKernel > 1) ? $clog2(MaxKernel) : 1,
  parameter int unsigned WAW = $clog2(MaxKernel * MaxKernel * MaxKernel + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wt_we_i,
  input  logic [WAW-1:0]     wt_addr_i,
  input  logic               px_we_i,
  input  logic [SW-1:0]      px_slot_i,
  input  logic [YW-1:0]      px_y_i,
  input  logic [XW-1:0]      px_x_i,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic [2:0]         k_i,
  input  logic               job_i,
  input  job_t               job_data_i,
  output logic               busy_o,
  output logic               empty_o,
  input  logic               pop_i,
  output logic signed [ValueW-1:0] out_value_o,
  output job_t               out_job_o
);

  localparam int unsigned WWords = MaxKernel * MaxKernel * MaxKernel;
  localparam int unsigned PWords = MaxKernel * MaxHeight * MaxWidth;
  localparam int unsigned PAW = $clog2(PWords + 1);

  logic signed [SampleW-1:0] pmem [PWords];
  logic signed [SampleW-1:0] wmem [WWords];
  logic signed [SampleW-1:0] ps_q, wt_q;

  bk_state_e st_q, st_d;
  job_t job_q;
  logic [2:0] kx_q, kx_d, ky_q, ky_d, kz_q, kz_d, k;
  logic [SW-1:0] sl_q, sl_d, zslot;
  logic [WAW-1:0] wi_q, wi_d;
  logic [1:0] vld_q, vld_d;
  logic signed [AccW-1:0] acc_q, acc_d, prod_q;
  logic signed [ValueW-1:0] res_q, res_d;
  logic full_q, full_d;
  logic rd;
  logic [PAW-1:0] raddr, waddr;
  logic signed [AccW-1:0] biased;
  logic [10:0] sx, sy, tmp;

  always_comb begin
    k = (k_i == '0) ? 3'd1 : ((32'(k_i) > MaxKernel) ? 3'(MaxKernel) : k_i);
    tmp = 11'(sl_q) + 11'(kz_q);
    zslot = (tmp >= 11'(MaxKernel)) ? SW'(tmp - 11'(MaxKernel)) : SW'(tmp);
    sx = 11'(job_q.ox) + 11'(kx_q);
    sy = 11'(job_q.oy) + 11'(ky_q);
    raddr = PAW'((32'(zslot) * MaxHeight + 32'(sy)) * MaxWidth + 32'(sx));
    waddr = PAW'((32'(px_slot_i) * MaxHeight + 32'(px_y_i)) * MaxWidth + 32'(px_x_i));
  end

  always_ff @(posedge clk_i) begin
    if (px_we_i) pmem[waddr] <= sample_i;
    if (wt_we_i) wmem[wt_addr_i] <= sample_i;
    if (rd) begin
      ps_q <= pmem[raddr];
      wt_q <= wmem[wi_q];
    end
    prod_q <= AccW'(ps_q) * AccW'(wt_q);
    if (job_i && st_q == BkIdle) job_q <= job_data_i;
    res_q <= res_d;
  end

  always_comb begin
    st_d = st_q; kx_d = kx_q; ky_d = ky_q; kz_d = kz_q; wi_d = wi_q;
    sl_d = sl_q; acc_d = acc_q; vld_d = {vld_q[0], 1'b0}; full_d = full_q;
    res_d = res_q; rd = 1'b0;
    biased = acc_q + AccW'(8192);
    if (vld_q[1]) acc_d = acc_q + prod_q;
    case (st_q)
      BkIdle: begin
        if (job_i) begin
          st_d = BkRun; kx_d = '0; ky_d = '0; kz_d = '0; wi_d = '0; acc_d = '0;
          sl_d = (px_slot_i >= SW'(k - 3'd1)) ? SW'(px_slot_i - SW'(k - 3'd1))
                 : SW'(11'(px_slot_i) + 11'(MaxKernel) - 11'(k) + 11'd1);
        end
      end
      BkRun: begin
        rd = 1'b1; vld_d[0] = 1'b1; wi_d = wi_q + WAW'(1);
        if (kx_q + 3'd1 < k) kx_d = kx_q + 3'd1;
        else begin
          kx_d = '0;
          if (ky_q + 3'd1 < k) ky_d = ky_q + 3'd1;
          else begin
            ky_d = '0;
            if (kz_q + 3'd1 < k) kz_d = kz_q + 3'd1;
            else st_d = BkDrain;
          end
        end
      end
      BkDrain: begin
        if (!vld_q[0] && !vld_q[1]) st_d = BkOut;
      end
      BkOut: begin
        if (!full_q) begin
          if (biased[AccW-1:14+ValueW-1] != '0 && biased[AccW-1:14+ValueW-1] != '1)
            res_d = biased[AccW-1] ? {1'b1, {(ValueW-1){1'b0}}} : {1'b0, {(ValueW-1){1'b1}}};
          else res_d = biased[14+ValueW-1:14];
          full_d = 1'b1; st_d = BkIdle;
        end
      end
      default: st_d = BkIdle;
    endcase
    if (full_q && pop_i) full_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BkIdle; vld_q <= '0; full_q <= 1'b0;
      kx_q <= '0; ky_q <= '0; kz_q <= '0; wi_q <= '0; sl_q <= '0; acc_q <= '0;
    end else begin
      st_q <= st_d; vld_q <= vld_d; full_q <= full_d;
      kx_q <= kx_d; ky_q <= ky_d; kz_q <= kz_d; wi_q <= wi_d; sl_q <= sl_d; acc_q <= acc_d;
    end
  end

  assign busy_o = (st_q != BkIdle);
  assign empty_o = !full_q;
  assign out_value_o = res_q;
  always_ff @(posedge clk_i) if (st_q == BkOut && !full_q) out_job_o <= job_q;

endmodule

@@ tb/tb_conv3d_valid_stream_top.sv @@
`timescale 1ns / 100ps

module tb_conv3d_valid_stream_top;
  import c3d_pkg::*;

  localparam int unsigned PlaneWords  = DefMaxKernel * DefMaxHeight * DefMaxWidth;
  localparam int unsigned WeightWords = DefMaxKernel * DefMaxKernel * DefMaxKernel;
  localparam int unsigned SettleCycles = 200;

  typedef struct {
    logic signed [ValueW-1:0] value;
    logic [CoordW-1:0]        x;
    logic [CoordW-1:0]        y;
    logic [CoordW-1:0]        z;
    logic                     last;
  } conv_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic action_i = 1'b0;
  logic [IdxW-1:0] weight_index_i = '0;
  logic signed [SampleW-1:0] sample_value_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [ValueW-1:0] out_value_o;
  logic [CoordW-1:0] out_x_o;
  logic [CoordW-1:0] out_y_o;
  logic [CoordW-1:0] out_z_o;
  logic last_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;

  logic signed [SampleW-1:0] vox_mem [PlaneWords];
  logic signed [SampleW-1:0] coef_mem [WeightWords];
  int unsigned cur_x, cur_y, cur_z;
  logic [CfgW-1:0] reg_w, reg_h, reg_d;
  logic [2:0] reg_k;

  conv_result_t pending_q[$];
  int errors = 0;
  int voxels_sent = 0;
  int weights_sent = 0;
  int results_seen = 0;
  bit idle_on = 1'b1;
  int stall_left = 0;

  conv3d_valid_stream_top u_top (
    .clk_i, .rst_ni, .push, .full, .action_i, .weight_index_i, .sample_value_i,
    .empty, .pop, .out_value_o, .out_x_o, .out_y_o, .out_z_o, .last_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #4 clk_i = ~clk_i;

  function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned vox_addr(int unsigned x, int unsigned y, int unsigned z);
    return ((z % DefMaxKernel) * DefMaxHeight + y) * DefMaxWidth + x;
  endfunction

  // Updates the local copy of the block for one accepted word.
  function automatic void predict_word(logic act, logic [IdxW-1:0] idx,
                                       logic signed [SampleW-1:0] smp);
    int unsigned w, h, d, k, ox, oy, oz;
    longint acc, r;
    conv_result_t res;
    w = clamp_dim(32'(reg_w), DefMaxWidth);
    h = clamp_dim(32'(reg_h), DefMaxHeight);
    d = clamp_dim(32'(reg_d), DefMaxDepth);
    k = clamp_dim(32'(reg_k), DefMaxKernel);
    if (!act) begin
      if (idx < WeightWords) coef_mem[idx] = smp;
      return;
    end
    if (cur_x >= w || cur_y >= h || cur_z >= d) begin
      cur_x = 0; cur_y = 0; cur_z = 0;
    end
    vox_mem[vox_addr(cur_x, cur_y, cur_z)] = smp;
    if (cur_x + 1 >= k && cur_y + 1 >= k && cur_z + 1 >= k) begin
      ox = cur_x + 1 - k;
      oy = cur_y + 1 - k;
      oz = cur_z + 1 - k;
      acc = 0;
      for (int unsigned kz = 0; kz < k; kz++)
        for (int unsigned ky = 0; ky < k; ky++)
          for (int unsigned kx = 0; kx < k; kx++)
            acc += longint'(vox_mem[vox_addr(ox + kx, oy + ky, oz + kz)]) *
                   longint'(coef_mem[kx + k * (ky + k * kz)]);
      r = (acc + 8192) >>> 14;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      res.value = r[ValueW-1:0];
      res.x = ox[CoordW-1:0];
      res.y = oy[CoordW-1:0];
      res.z = oz[CoordW-1:0];
      res.last = (cur_x == w - 1 && cur_y == h - 1 && cur_z == d - 1);
      pending_q.push_back(res);
    end
    if (cur_x + 1 < w) begin
      cur_x++;
    end else begin
      cur_x = 0;
      if (cur_y + 1 < h) begin
        cur_y++;
      end else begin
        cur_y = 0;
        cur_z = (cur_z + 1 < d) ? cur_z + 1 : 0;
      end
    end
  endfunction

  task automatic send_word(logic act, logic [IdxW-1:0] idx, logic signed [SampleW-1:0] smp);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk_i);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    push <= 1'b1;
    action_i <= act;
    weight_index_i <= idx;
    sample_value_i <= smp;
    do @(posedge clk_i); while (full);
    predict_word(act, idx, smp);
    if (act) voxels_sent++;
    else weights_sent++;
  endtask

  task automatic settle();
    @(negedge clk_i);
    push <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e r, logic [CfgW-1:0] v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= r;
    cfg_data_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (r)
      RegWidth:  reg_w = v;
      RegHeight: reg_h = v;
      RegDepth:  reg_d = v;
      RegKernel: reg_k = v[2:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [CfgW-1:0] w, logic [CfgW-1:0] h, logic [CfgW-1:0] d,
                           logic [CfgW-1:0] k);
    settle();
    write_reg(RegWidth, w);
    write_reg(RegHeight, h);
    write_reg(RegDepth, d);
    write_reg(RegKernel, k);
  endtask

  function automatic logic signed [SampleW-1:0] pick_sample(bit extreme);
    if (extreme) return ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
    return SampleW'($urandom());
  endfunction

  task automatic send_voxels(int n, bit extreme, bit noise);
    for (int i = 0; i < n; i++) begin
      if (noise && $urandom_range(0, 9) == 0)
        send_word(1'b0, IdxW'($urandom_range(0, 127)), SampleW'($urandom()));
      send_word(1'b1, '0, pick_sample(extreme));
    end
  endtask

  task automatic test_weight_load();
    for (int i = 0; i < WeightWords; i++)
      send_word(1'b0, IdxW'(i), (i % 2) ? 16'sh7FFF : 16'sh8000);
    send_word(1'b0, 7'd125, 16'sh1234);
    send_word(1'b0, 7'd127, 16'sh4321);
  endtask

  task automatic test_extremes();
    configure(7'd5, 7'd5, 7'd5, 7'd5);
    send_voxels(125, 1'b1, 1'b0);
    configure(7'd64, 7'd1, 7'd1, 7'd1);
    send_voxels(64, 1'b1, 1'b0);
    configure(7'd1, 7'd64, 7'd1, 7'd1);
    send_voxels(64, 1'b1, 1'b0);
    configure(7'd1, 7'd1, 7'd64, 7'd1);
    send_voxels(64, 1'b1, 1'b0);
  endtask

  task automatic test_clamping();
    configure(7'd0, 7'd0, 7'd0, 7'd0);
    send_voxels(3, 1'b1, 1'b0);
    configure(7'd100, 7'd127, 7'd1, 7'd7);
    send_voxels(64, 1'b0, 1'b0);
    configure(7'd2, 7'd2, 7'd2, 7'd4);
    send_voxels(8, 1'b0, 1'b0);
  endtask

  task automatic test_position_reset();
    configure(7'd4, 7'd4, 7'd4, 7'd2);
    send_voxels(20, 1'b0, 1'b0);
    @(negedge clk_i);
    push <= 1'b0;
    wait (pending_q.size() == 0);
    send_voxels(5, 1'b0, 1'b0);
    configure(7'd4, 7'd1, 7'd4, 7'd1);
    send_voxels(16, 1'b0, 1'b0);
  endtask

  task automatic test_random_volumes(int budget);
    int start, w, h, d, k;
    start = voxels_sent + weights_sent;
    while (voxels_sent + weights_sent - start < budget) begin
      w = $urandom_range(1, 6);
      h = $urandom_range(1, 6);
      d = $urandom_range(1, 6);
      k = $urandom_range(1, 3);
      if ($urandom_range(0, 4) == 0) k = $urandom_range(1, 5);
      configure(CfgW'(w), CfgW'(h), CfgW'(d), CfgW'(k));
      send_voxels(w * h * d, 1'b0, 1'b1);
    end
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    configure(7'd4, 7'd3, 7'd3, 7'd2);
    send_voxels(36, 1'b0, 1'b1);
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      pop <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 4);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    conv_result_t exp_res;
    if (rst_ni && pop && !empty) begin
      if (pending_q.size() == 0) begin
        $error("result word with nothing expected: value %0d", out_value_o);
        errors++;
      end else begin
        exp_res = pending_q.pop_front();
        results_seen++;
        if (out_value_o !== exp_res.value) begin
          $error("out_value expected %0d got %0d", exp_res.value, out_value_o);
          errors++;
        end
        if (out_x_o !== exp_res.x) begin
          $error("out_x expected %0d got %0d", exp_res.x, out_x_o);
          errors++;
        end
        if (out_y_o !== exp_res.y) begin
          $error("out_y expected %0d got %0d", exp_res.y, out_y_o);
          errors++;
        end
        if (out_z_o !== exp_res.z) begin
          $error("out_z expected %0d got %0d", exp_res.z, out_z_o);
          errors++;
        end
        if (last_o !== exp_res.last) begin
          $error("last expected %0d got %0d", exp_res.last, last_o);
          errors++;
        end
      end
    end
  end

  initial begin
    #8ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    cur_x = 0; cur_y = 0; cur_z = 0;
    reg_w = 7'd8; reg_h = 7'd8; reg_d = 7'd8; reg_k = 3'd3;
    for (int i = 0; i < PlaneWords; i++) vox_mem[i] = '0;
    for (int i = 0; i < WeightWords; i++) coef_mem[i] = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_weight_load();
    test_extremes();
    test_clamping();
    test_position_reset();
    test_random_volumes(50);
    test_back_to_back();
    settle();
    $display("Sent %0d voxel words and %0d weight words, checked %0d results.",
             voxels_sent, weights_sent, results_seen);
    $display("Covered extreme dimensions, clamping, kernel overrun and position reset.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
